// ===== hdl/weak_learner_stump_search_assert.svh =====
// Assertion macros for the stump search datapath.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef WEAK_LEARNER_STUMP_SEARCH_ASSERT_SVH
`define WEAK_LEARNER_STUMP_SEARCH_ASSERT_SVH

// Same-cycle implication, written by the caller.
`define WLS_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition in one cycle, consequence in the next.
`define WLS_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) \
        else $error(msg);

`endif

// ===== hdl/wls_pkg.sv =====
package wls_pkg;

    localparam int WEIGHT_BITS = 32;
    localparam int ACC_W       = WEIGHT_BITS + 2;
    localparam int ERR_W       = WEIGHT_BITS + 1;
    localparam int SUM_W       = ACC_W + 1;
    localparam int CALC_W      = ACC_W + 3;
    localparam int MAX_LABELS  = 16;
    localparam int LBL_W       = 4;
    localparam int IDX_W       = 16;
    localparam int FEAT_W      = 20;
    localparam int CNT_W       = 5;
    localparam int OP_W        = 2;

    localparam logic [ERR_W-1:0] ONE_VAL = {1'b1, {WEIGHT_BITS{1'b0}}};
    localparam logic [CNT_W-1:0] LBL_CNT_RST = CNT_W'(2);

    // Operation codes of an input item
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_MEMBER = 2'd1;
    localparam logic [OP_W-1:0] OP_EMIT   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic member;
        logic accum;
        logic scan;
        logic drain;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last;
        logic scan_empty;
        logic scan_last;
    } t_dp_sts;

    // Add a weight to an accumulator, saturating at all ones
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [WEIGHT_BITS-1:0] b);
        logic [SUM_W-1:0] s;
        s = {1'b0, a} + SUM_W'(b);
        return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    endfunction

    // Rule error ft + lt - 2*fls, clamped to [0, 1.0]
    function automatic logic [ERR_W-1:0] err_calc(input logic [ACC_W-1:0] ft,
                                                  input logic [ACC_W-1:0] lt,
                                                  input logic [ACC_W-1:0] fls);
        logic signed [CALC_W-1:0] e;
        e = $signed(CALC_W'(ft)) + $signed(CALC_W'(lt)) - $signed(CALC_W'({fls, 1'b0}));
        if (e < 0) begin
            return '0;
        end else if (e > $signed(CALC_W'(ONE_VAL))) begin
            return ONE_VAL;
        end else begin
            return e[ERR_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/wls_ctrl.sv =====
module wls_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic [wls_pkg::OP_W-1:0]  i_op,
    input  wls_pkg::t_dp_sts          i_sts,
    output wls_pkg::t_dp_cmd          o_cmd,
    output logic                      busy
);
    import wls_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (i_op)
                        OP_LOAD: begin
                            o_cmd.load = 1'b1;
                        end
                        OP_MEMBER: begin
                            o_cmd.member = 1'b1;
                            n_state      = ST_ACCUM;
                        end
                        OP_EMIT: begin
                            o_cmd.emit = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ACCUM: begin
                o_cmd.accum = 1'b1;
                if (i_sts.last) begin
                    n_state = i_sts.scan_empty ? ST_DRAIN : ST_SCAN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                o_cmd.drain = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

// ===== hdl/wls_dp.sv =====
`include "weak_learner_stump_search_assert.svh"

module wls_dp #(
    parameter int MAX_EXAMPLES = 65536
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wls_pkg::t_dp_cmd                 i_cmd,
    output wls_pkg::t_dp_sts                 o_sts,
    input  logic [wls_pkg::IDX_W-1:0]        i_example_index,
    input  logic [wls_pkg::LBL_W-1:0]        i_example_label,
    input  logic [wls_pkg::WEIGHT_BITS-1:0]  i_weight,
    input  logic [wls_pkg::FEAT_W-1:0]       i_feature_number,
    input  logic                             i_last_member,
    input  logic                             i_cfg_valid,
    input  logic [wls_pkg::CNT_W-1:0]        i_cfg_data,
    output logic                             o_done,
    output logic                             o_found,
    output logic [wls_pkg::FEAT_W-1:0]       o_best_feature_number,
    output logic [wls_pkg::LBL_W-1:0]        o_best_label_index,
    output logic [wls_pkg::ERR_W-1:0]        o_best_error_value
);
    import wls_pkg::*;

    localparam int AW = (MAX_EXAMPLES > 1) ? $clog2(MAX_EXAMPLES) : 1;

    // Example memory: label in the upper bits, weight below
    logic [LBL_W+WEIGHT_BITS-1:0] r_mem [MAX_EXAMPLES];
    logic [LBL_W-1:0]             r_rd_label;
    logic [WEIGHT_BITS-1:0]       r_rd_weight;

    logic                         r_rd_ok;
    logic                         r_last;
    logic [FEAT_W-1:0]            r_fnum;

    logic [ACC_W-1:0]             r_lt  [MAX_LABELS];
    logic [ACC_W-1:0]             r_fls [MAX_LABELS];
    logic [ACC_W-1:0]             r_ft;

    logic [CNT_W-1:0]             r_lbl_cnt;
    logic [LBL_W-1:0]             r_k;
    logic [LBL_W-1:0]             r_err_k;
    logic [ERR_W-1:0]             r_err;
    logic                         r_err_vld;

    logic                         r_best_valid;
    logic [ERR_W-1:0]             r_best_err;
    logic [FEAT_W-1:0]            r_best_feat;
    logic [LBL_W-1:0]             r_best_lbl;

    logic                         r_done;
    logic                         r_out_found;
    logic [FEAT_W-1:0]            r_out_feat;
    logic [LBL_W-1:0]             r_out_lbl;
    logic [ERR_W-1:0]             r_out_err;

    logic [AW-1:0]                addr;
    logic                         in_rng;
    logic [LBL_W-1:0]             lt_sel;
    logic [LBL_W-1:0]             fls_sel;
    logic [ACC_W-1:0]             lt_rd;
    logic [ACC_W-1:0]             fls_rd;
    logic [CNT_W-1:0]             n_scan;
    logic [ERR_W-1:0]             err_now;
    logic                         better;

    // Address decode and range check
    assign addr   = AW'(i_example_index);
    assign in_rng = (32'(i_example_index) < 32'(MAX_EXAMPLES));

    // One read port per label array: label totals shared by load and scan, feature sums by accumulate and scan
    assign lt_sel  = i_cmd.scan ? r_k : i_example_label;
    assign fls_sel = i_cmd.scan ? r_k : r_rd_label;
    assign lt_rd   = r_lt[lt_sel];
    assign fls_rd  = r_fls[fls_sel];

    // Labels to scan, limited to the array depth
    assign n_scan = (r_lbl_cnt > CNT_W'(MAX_LABELS)) ? CNT_W'(MAX_LABELS) : r_lbl_cnt;

    assign o_sts.last       = r_last;
    assign o_sts.scan_empty = (n_scan == '0);
    assign o_sts.scan_last  = ((CNT_W'(r_k) + CNT_W'(1)) == n_scan);

    // Score of the label under scan
    assign err_now = err_calc(r_ft, lt_rd, fls_rd);

    // Replace on lower error, or equal error and lower feature number
    assign better = !r_best_valid || (r_err < r_best_err) ||
                    ((r_err == r_best_err) && (r_fnum < r_best_feat));

    // Example memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && in_rng) begin
            r_mem[addr] <= {i_example_label, i_weight};
        end
        if (i_cmd.member) begin
            {r_rd_label, r_rd_weight} <= r_mem[addr];
        end
    end

    // Capture member item and scan results
    always_ff @(posedge i_clk) begin
        if (i_cmd.member) begin
            r_rd_ok <= in_rng;
            r_last  <= i_last_member;
            r_fnum  <= i_feature_number;
        end
        if (i_cmd.scan) begin
            r_err   <= err_now;
            r_err_k <= r_k;
        end
    end

    // Accumulators, best rule and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lbl_cnt    <= LBL_CNT_RST;
            for (int i = 0; i < MAX_LABELS; i++) begin
                r_lt[i]  <= '0;
                r_fls[i] <= '0;
            end
            r_ft         <= '0;
            r_k          <= '0;
            r_err_vld    <= 1'b0;
            r_best_valid <= 1'b0;
            r_best_err   <= '0;
            r_best_feat  <= '0;
            r_best_lbl   <= '0;
            r_done       <= 1'b0;
            r_out_found  <= 1'b0;
            r_out_feat   <= '0;
            r_out_lbl    <= '0;
            r_out_err    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_lbl_cnt <= i_cfg_data;
            end

            // Add the loaded weight to its label total
            if (i_cmd.load && in_rng) begin
                r_lt[i_example_label] <= sat_add(lt_rd, i_weight);
            end

            // Add the member's weight to the feature sums
            if (i_cmd.accum) begin
                r_k <= '0;
                if (r_rd_ok) begin
                    r_ft             <= sat_add(r_ft, r_rd_weight);
                    r_fls[r_rd_label] <= sat_add(fls_rd, r_rd_weight);
                end
            end

            // Advance the label counter
            if (i_cmd.scan) begin
                r_k <= r_k + LBL_W'(1);
            end
            r_err_vld <= i_cmd.scan;

            // Compare the scored label against the best rule
            if (r_err_vld && better) begin
                r_best_valid <= 1'b1;
                r_best_err   <= r_err;
                r_best_feat  <= r_fnum;
                r_best_lbl   <= r_err_k;
            end

            // Drop the feature sums after the scan
            if (i_cmd.drain) begin
                for (int i = 0; i < MAX_LABELS; i++) begin
                    r_fls[i] <= '0;
                end
                r_ft <= '0;
            end

            // Emit the best rule and clear the round
            r_done <= i_cmd.emit;
            if (i_cmd.emit) begin
                r_out_found  <= r_best_valid;
                r_out_feat   <= r_best_valid ? r_best_feat : '0;
                r_out_lbl    <= r_best_valid ? r_best_lbl : '0;
                r_out_err    <= r_best_valid ? r_best_err : ONE_VAL;
                for (int i = 0; i < MAX_LABELS; i++) begin
                    r_lt[i]  <= '0;
                    r_fls[i] <= '0;
                end
                r_ft         <= '0;
                r_best_valid <= 1'b0;
                r_best_err   <= '0;
                r_best_feat  <= '0;
                r_best_lbl   <= '0;
            end
        end
    end

    assign o_done                = r_done;
    assign o_found               = r_out_found;
    assign o_best_feature_number = r_out_feat;
    assign o_best_label_index    = r_out_lbl;
    assign o_best_error_value    = r_out_err;

    `WLS_CHECK(a_emit_after_drain, i_cmd.emit |-> !r_err_vld, "emit while compare pending")
    `WLS_CHECK_NEXT(a_emit_clears, i_cmd.emit, !r_best_valid && (r_ft == '0), "round not cleared")
    `WLS_CHECK(a_err_clamped, r_err_vld |-> (r_err <= ONE_VAL), "error above 1.0")

endmodule

// ===== hdl/weak_learner_stump_search.sv =====
// Member item: memory read, then accumulate.
// Last member of a feature: memory read, accumulate, scan of N = min(label_count, 16)
// labels, one label per cycle through the shared error unit, then drain; busy is high from accumulate through drain.
// Emit item: the result strobe o_done rises the cycle after acceptance.
// The receiver cannot stall. Synchronous active-low reset clears totals, best rule and
// control state and sets label_count to 2; the example memory is not cleared.
module weak_learner_stump_search #(
    parameter int MAX_EXAMPLES = 65536
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [wls_pkg::OP_W-1:0]         i_op,
    input  logic [wls_pkg::IDX_W-1:0]        i_example_index,
    input  logic [wls_pkg::LBL_W-1:0]        i_example_label,
    input  logic [wls_pkg::WEIGHT_BITS-1:0]  i_weight,
    input  logic [wls_pkg::FEAT_W-1:0]       i_feature_number,
    input  logic                             i_last_member,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [wls_pkg::CNT_W-1:0]        i_cfg_data,
    output logic                             o_done,
    output logic                             o_found,
    output logic [wls_pkg::FEAT_W-1:0]       o_best_feature_number,
    output logic [wls_pkg::LBL_W-1:0]        o_best_label_index,
    output logic [wls_pkg::ERR_W-1:0]        o_best_error_value
);
    import wls_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Configuration is taken in any cycle
    assign o_cfg_ready = 1'b1;

    wls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_op),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    wls_dp #(
        .MAX_EXAMPLES (MAX_EXAMPLES)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_sts                 (sts),
        .i_example_index       (i_example_index),
        .i_example_label       (i_example_label),
        .i_weight              (i_weight),
        .i_feature_number      (i_feature_number),
        .i_last_member         (i_last_member),
        .i_cfg_valid           (i_cfg_valid),
        .i_cfg_data            (i_cfg_data),
        .o_done                (o_done),
        .o_found               (o_found),
        .o_best_feature_number (o_best_feature_number),
        .o_best_label_index    (o_best_label_index),
        .o_best_error_value    (o_best_error_value)
    );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import wls_pkg::*;

    // The block ignores this operation code
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    // Longest item: last member with 16 labels scanned, plus margin
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int PHASES        = 6;

    typedef struct packed {
        logic              found;
        logic [FEAT_W-1:0] feature;
        logic [LBL_W-1:0]  label;
        logic [ERR_W-1:0]  error;
    } t_best_rule;

    // Predict the best rule of each round and compare it with the emitted one
    class t_stump_scoreboard;
        logic [LBL_W-1:0]       label_mem [0:65535];
        logic [WEIGHT_BITS-1:0] weight_mem [0:65535];
        logic [ACC_W-1:0]       label_total [MAX_LABELS];
        logic [ACC_W-1:0]       feat_label_total [MAX_LABELS];
        logic [ACC_W-1:0]       feat_total;
        logic [ERR_W-1:0]       best_error;
        logic [FEAT_W-1:0]      best_feature;
        logic [LBL_W-1:0]       best_label;
        bit                     best_ok;
        logic [CNT_W-1:0]       label_count;
        t_best_rule             pending_rules[$];
        int                     fail_count;

        function new();
            clear_round();
            label_count = LBL_CNT_RST;
            fail_count  = 0;
        endfunction

        function void clear_feature();
            foreach (feat_label_total[k]) feat_label_total[k] = '0;
            feat_total = '0;
        endfunction

        function void clear_round();
            foreach (label_total[k]) label_total[k] = '0;
            clear_feature();
            best_error   = '0;
            best_feature = '0;
            best_label   = '0;
            best_ok      = 1'b0;
        endfunction

        // Accumulate a weight, pinning at all ones on overflow
        function logic [ACC_W-1:0] acc_add(logic [ACC_W-1:0] acc, logic [WEIGHT_BITS-1:0] w);
            logic [ACC_W:0] total;
            total = {1'b0, acc} + (ACC_W + 1)'(w);
            if (total[ACC_W]) return {ACC_W{1'b1}};
            return total[ACC_W-1:0];
        endfunction

        // Score every label in use for the finished feature and keep the least error
        function void rank_labels(logic [FEAT_W-1:0] fnum);
            int          n;
            longint      e;
            logic [ERR_W-1:0] err;
            n = (label_count > MAX_LABELS) ? MAX_LABELS : int'(label_count);
            for (int k = 0; k < n; k++) begin
                e = longint'(feat_total) + longint'(label_total[k])
                  - 2 * longint'(feat_label_total[k]);
                if (e < 0) begin
                    err = '0;
                end else if (e > longint'(ONE_VAL)) begin
                    err = ONE_VAL;
                end else begin
                    err = ERR_W'(e);
                end
                if (!best_ok || err < best_error || (err == best_error && fnum < best_feature)) begin
                    best_ok      = 1'b1;
                    best_error   = err;
                    best_feature = fnum;
                    best_label   = LBL_W'(k);
                end
            end
        endfunction

        // Apply one accepted item to the predicted state
        function void take_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                logic [LBL_W-1:0] lab, logic [WEIGHT_BITS-1:0] w,
                                logic [FEAT_W-1:0] fnum, logic last);
            t_best_rule rule;
            case (op)
                OP_LOAD: begin
                    label_mem[idx]   = lab;
                    weight_mem[idx]  = w;
                    label_total[lab] = acc_add(label_total[lab], w);
                end
                OP_MEMBER: begin
                    feat_total = acc_add(feat_total, weight_mem[idx]);
                    feat_label_total[label_mem[idx]] =
                        acc_add(feat_label_total[label_mem[idx]], weight_mem[idx]);
                    if (last) begin
                        rank_labels(fnum);
                        clear_feature();
                    end
                end
                OP_EMIT: begin
                    rule.found   = best_ok;
                    rule.feature = best_ok ? best_feature : '0;
                    rule.label   = best_ok ? best_label : '0;
                    rule.error   = best_ok ? best_error : ONE_VAL;
                    pending_rules.push_back(rule);
                    clear_round();
                end
                default: ;
            endcase
        endfunction

        task report(string what);
            $display("MISMATCH: %s", what);
            fail_count++;
        endtask

        // Compare an emitted rule with the oldest prediction
        task check_rule(t_best_rule got);
            t_best_rule want;
            if (pending_rules.size() == 0) begin
                report($sformatf("rule emitted with none pending: %h", got));
                return;
            end
            want = pending_rules.pop_front();
            if (got.found !== want.found)
                report($sformatf("found %b, want %b", got.found, want.found));
            if (got.feature !== want.feature)
                report($sformatf("feature %h, want %h", got.feature, want.feature));
            if (got.label !== want.label)
                report($sformatf("label %h, want %h", got.label, want.label));
            if (got.error !== want.error)
                report($sformatf("error %h, want %h", got.error, want.error));
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [OP_W-1:0]        i_op = OP_UNUSED;
    logic [IDX_W-1:0]       i_example_index = '0;
    logic [LBL_W-1:0]       i_example_label = '0;
    logic [WEIGHT_BITS-1:0] i_weight = '0;
    logic [FEAT_W-1:0]      i_feature_number = '0;
    logic                   i_last_member = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CNT_W-1:0]       i_cfg_data = '0;
    logic                   o_done;
    logic                   o_found;
    logic [FEAT_W-1:0]      o_best_feature_number;
    logic [LBL_W-1:0]       o_best_label_index;
    logic [ERR_W-1:0]       o_best_error_value;

    t_stump_scoreboard sb = new();
    bit              slot_written [0:65535];
    int              written_slots[$];
    int              items_sent = 0;
    int              cycle_count = 0;
    bit              idle_on = 1'b1;

    weak_learner_stump_search dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_op                  (i_op),
        .i_example_index       (i_example_index),
        .i_example_label       (i_example_label),
        .i_weight              (i_weight),
        .i_feature_number      (i_feature_number),
        .i_last_member         (i_last_member),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_data            (i_cfg_data),
        .o_done                (o_done),
        .o_found               (o_found),
        .o_best_feature_number (o_best_feature_number),
        .o_best_label_index    (o_best_label_index),
        .o_best_error_value    (o_best_error_value)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Check each emitted rule on the edge that ends its strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            sb.check_rule({o_found, o_best_feature_number, o_best_label_index,
                           o_best_error_value});
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Present one item, hold it until accepted, then maybe idle
    task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [LBL_W-1:0] lab, input logic [WEIGHT_BITS-1:0] w,
                             input logic [FEAT_W-1:0] fnum, input logic last);
        start            <= 1'b1;
        i_op             <= op;
        i_example_index  <= idx;
        i_example_label  <= lab;
        i_weight         <= w;
        i_feature_number <= fnum;
        i_last_member    <= last;
        do @(posedge i_clk); while (busy);
        sb.take_item(op, idx, lab, w, fnum, last);
        if (op != OP_UNUSED) items_sent++;
        if (idle_on && $urandom_range(0, 99) < 36) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic load_example(input logic [IDX_W-1:0] idx, input logic [LBL_W-1:0] lab,
                                input logic [WEIGHT_BITS-1:0] w);
        send_item(OP_LOAD, idx, lab, w, FEAT_W'($urandom), 1'($urandom));
        if (!slot_written[idx]) begin
            slot_written[idx] = 1'b1;
            written_slots.push_back(int'(idx));
        end
    endtask

    task automatic add_member(input logic [IDX_W-1:0] idx, input logic [FEAT_W-1:0] fnum,
                              input logic last);
        send_item(OP_MEMBER, idx, LBL_W'($urandom), WEIGHT_BITS'($urandom), fnum, last);
    endtask

    task automatic emit_rule();
        send_item(OP_EMIT, IDX_W'($urandom), LBL_W'($urandom), WEIGHT_BITS'($urandom),
                  FEAT_W'($urandom), 1'($urandom));
    endtask

    function automatic logic [WEIGHT_BITS-1:0] pick_weight();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return WEIGHT_BITS'($urandom_range(0, 255));
            default: return WEIGHT_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_written();
        return IDX_W'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
    endfunction

    // Ignored op, reload of a known slot, or an emit that cuts the round short
    task automatic noise_item();
        case ($urandom_range(0, 2))
            0: send_item(OP_UNUSED, IDX_W'($urandom), LBL_W'($urandom),
                         WEIGHT_BITS'($urandom), FEAT_W'($urandom), 1'($urandom));
            1: load_example(pick_written(), LBL_W'($urandom), pick_weight());
            default: emit_rule();
        endcase
    endtask

    // One boosting round: load examples, stream features, emit the best rule
    task automatic run_round();
        int                n_feats;
        int                n_members;
        logic [FEAT_W-1:0] fnum;
        repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 1))
                load_example(IDX_W'($urandom_range(0, 255)), LBL_W'($urandom), pick_weight());
            else
                load_example(IDX_W'($urandom), LBL_W'($urandom), pick_weight());
        end
        n_feats = $urandom_range(0, 5);
        repeat (n_feats) begin
            case ($urandom_range(0, 4))
                0:       fnum = '0;
                1:       fnum = '1;
                2:       fnum = FEAT_W'($urandom_range(0, 7));
                default: fnum = FEAT_W'($urandom);
            endcase
            n_members = $urandom_range(1, 6);
            for (int m = 0; m < n_members; m++) begin
                if ($urandom_range(0, 99) < 6) noise_item();
                // Leave the last flag off now and then so features merge
                add_member(pick_written(), fnum,
                           (m == n_members - 1) && ($urandom_range(0, 9) != 0));
            end
        end
        emit_rule();
    endtask

    // Hold the sender until every rule is back and the block has settled
    task automatic drain();
        start <= 1'b0;
        while (sb.pending_rules.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_label_count(input logic [CNT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.label_count = value;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CNT_W-1:0] phase_counts [PHASES];
        phase_counts = '{5'd16, 5'd0, 5'd31, 5'd1, CNT_W'($urandom_range(3, 15)), 5'd2};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty round, ignored op, then extreme slots and weights
        emit_rule();
        send_item(OP_UNUSED, '1, '1, '1, '1, 1'b1);
        load_example(16'd0, 4'd0, 32'hFFFF_FFFF);
        load_example(16'hFFFF, 4'd15, 32'd0);
        load_example(16'd1, 4'd1, 32'h8000_0000);
        load_example(16'd2, 4'd0, 32'h4000_0000);
        add_member(16'd0, 20'hFFFFF, 1'b0);
        add_member(16'd1, 20'hFFFFF, 1'b1);
        // Equal errors: the smaller feature number takes over, an equal one does not
        add_member(16'd2, 20'd5, 1'b1);
        add_member(16'd2, 20'd3, 1'b1);
        add_member(16'd2, 20'd3, 1'b1);
        // Empty feature weight: error is the label total, clamped at 1.0
        add_member(16'hFFFF, 20'd0, 1'b1);
        emit_rule();
        // Stores survive the round end, so this error goes below zero
        add_member(16'd0, 20'd7, 1'b1);
        emit_rule();
        // Saturate label and feature accumulators
        for (int i = 3; i < 8; i++) load_example(IDX_W'(i), 4'd1, 32'hFFFF_FFFF);
        for (int i = 3; i < 8; i++) add_member(IDX_W'(i), 20'd9, i == 7);
        emit_rule();

        // Random rounds under several label counts, one phase without idling
        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_label_count(phase_counts[p]);
            idle_on = (p != 3);
            while (items_sent < (p + 1) * RANDOM_ITEMS / PHASES) run_round();
        end

        drain();
        if (sb.fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/wls_pkg.sv
hdl/wls_ctrl.sv
hdl/wls_dp.sv
hdl/weak_learner_stump_search.sv
bench/testbench.sv
